// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TCW_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TCW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/tcw_pkg.sv
// Types, constants and helpers for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] ATTR_AT_RESET  = 8'h07;

    typedef enum logic [1:0] {
        FUNC_PRINT    = 2'd0,
        FUNC_CLEAR    = 2'd1,
        FUNC_READ     = 2'd2,
        FUNC_SET_ATTR = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_FILL   = 2'd2,
        OP_SCROLL = 2'd3
    } store_op_t;

    typedef struct packed {
        logic      valid;
        store_op_t op;
    } store_req_t;

    // Cell layout: attribute in the high byte, character in the low byte.
    function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [7:0] attr);
        return {attr, ch};
    endfunction

endpackage

`default_nettype wire

// File: hdl/tcw_ifs.sv
// Request and response channel interfaces of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

interface tcw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
    logic [7:0]  attribute_value;

    modport source (output valid, func, char_code, cell_index, attribute_value, input ready);
    modport sink   (input valid, func, char_code, cell_index, attribute_value, output ready);
endinterface

interface tcw_rsp_if;
    logic        valid;
    logic        ready;
    logic [10:0] cursor_position;
    logic [7:0]  read_char;
    logic [7:0]  read_attribute;
    logic        scrolled;

    modport source (output valid, cursor_position, read_char, read_attribute, scrolled,
                    input ready);
    modport sink   (input valid, cursor_position, read_char, read_attribute, scrolled,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/tcw_store.sv
// Cell memory with single accesses and fill / scroll sweeps.
`timescale 1ns / 1ps
`default_nettype none

module tcw_store
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  store_req_t        req,
    input  logic [ADDR_W-1:0] addr,
    input  logic [15:0]       wr_cell,
    output logic              busy,
    output logic [15:0]       rdata
);

    localparam logic [ADDR_W-1:0] LAST_CELL      = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_LEN        = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_LAST      = ADDR_W'(COLUMNS * (ROWS - 1) - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'(COLUMNS * (ROWS - 1));

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_COPY,
        S_DRAIN
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   cnt_reg;
    logic [15:0]         fill_cell_reg;
    logic                copy_pend_reg;
    logic [ADDR_W-1:0]   copy_waddr_reg;
    logic [15:0]         rdata_reg;
    logic [15:0]         mem [CELLS];

    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [15:0]         mem_wdata;

    // Port steering. A copy read lands in rdata_reg and is written back in the following cycle.
    always_comb
    begin
        mem_we    = copy_pend_reg;
        mem_waddr = copy_pend_reg ? copy_waddr_reg : addr;
        mem_wdata = copy_pend_reg ? rdata_reg : wr_cell;
        mem_re    = 1'b0;
        mem_raddr = addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.op == OP_READ)
                begin
                    mem_re = 1'b1;
                end
                if (req.valid && req.op == OP_WRITE)
                begin
                    mem_we = 1'b1;
                end
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = fill_cell_reg;
            end
            S_COPY:
            begin
                mem_re    = 1'b1;
                mem_raddr = cnt_reg + ROW_LEN;
            end
            S_DRAIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Blank the whole store after reset.
            state_reg      <= S_FILL;
            cnt_reg        <= '0;
            fill_cell_reg  <= make_cell(CHAR_SPACE, ATTR_AT_RESET);
            copy_pend_reg  <= 1'b0;
            copy_waddr_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.op == OP_FILL)
                    begin
                        state_reg     <= S_FILL;
                        cnt_reg       <= '0;
                        fill_cell_reg <= wr_cell;
                    end
                    else if (req.valid && req.op == OP_SCROLL)
                    begin
                        state_reg     <= S_COPY;
                        cnt_reg       <= '0;
                        fill_cell_reg <= wr_cell;
                    end
                end
                S_FILL:
                begin
                    if (cnt_reg == LAST_CELL)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_COPY:
                begin
                    copy_pend_reg  <= 1'b1;
                    copy_waddr_reg <= cnt_reg;
                    if (cnt_reg == COPY_LAST)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    // last copy write goes out this cycle, then blank the bottom row
                    copy_pend_reg <= 1'b0;
                    state_reg     <= S_FILL;
                    cnt_reg       <= LAST_ROW_START;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign busy  = (state_reg != S_IDLE);
    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/text_console_writer.sv
// Top level of the text console writer: command sequencer, cursor and result register.
//
//   channel   dir  handshake             payload
//   req       in   req.valid/req.ready   func, char_code, cell_index, attribute_value
//   rsp       out  rsp.valid/rsp.ready   cursor_position, read_char, read_attribute, scrolled
//   cfg       in   cfg_wr_en             cfg_wr_data (default attribute)
//
// Print, read and set-attribute requests go through accept, execute and result.
// Clear adds a sweep over every cell; a scroll adds a sweep that copies each row up
// through the registered memory read, then blanks the bottom row.
// After reset the store is blanked; no request is taken meanwhile.
// A result waiting on rsp.ready does not block the next accept; the one after it waits.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic          clk,
    input  logic          rst_n,
    tcw_req_if.sink       req,
    tcw_rsp_if.source     rsp,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    typedef enum logic [2:0] {
        T_IDLE,
        T_EXEC,
        T_SCROLL,
        T_WAIT,
        T_DONE
    } state_t;

    state_t             state_reg;
    func_t              func_reg;
    logic [7:0]         char_reg;
    logic [10:0]        idx_reg;
    logic [7:0]         attr_in_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [7:0]         cur_attr_reg;
    logic [7:0]         def_attr_reg;
    logic               scrolled_reg;
    logic               rd_hit_reg;

    logic               rsp_valid_reg;
    logic [10:0]        rsp_pos_reg;
    logic [7:0]         rsp_char_reg;
    logic [7:0]         rsp_attr_reg;
    logic               rsp_scrolled_reg;

    store_req_t         st_req;
    logic [ADDR_W-1:0]  st_addr;
    logic [15:0]        st_cell;
    logic               st_busy;
    logic [15:0]        st_rdata;

    logic [ADDR_W-1:0]  cell_addr;
    logic               at_last_col;
    logic               at_last_row;
    logic               is_newline;
    logic               is_backspace;
    logic               rd_in_range;
    logic               rsp_free;

    assign cell_addr    = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(COLUMNS)) + ADDR_W'(col_reg);
    assign at_last_col  = (col_reg == COL_W'(COLUMNS - 1));
    assign at_last_row  = (row_reg == ROW_W'(ROWS - 1));
    assign is_newline   = (char_reg == CHAR_NEWLINE);
    assign is_backspace = (char_reg == CHAR_BACKSPACE);
    assign rd_in_range  = (32'(idx_reg) < 32'(CELLS));
    assign rsp_free     = !rsp_valid_reg || rsp.ready;

    assign req.ready = (state_reg == T_IDLE) && !st_busy;

    // Store access for the request in flight.
    always_comb
    begin
        st_req.valid = 1'b0;
        st_req.op    = OP_WRITE;
        st_addr      = cell_addr;
        st_cell      = make_cell(char_reg, cur_attr_reg);
        if (state_reg == T_EXEC)
        begin
            unique case (func_reg)
                FUNC_PRINT:
                begin
                    if (is_backspace)
                    begin
                        st_req.valid = (col_reg != '0);
                        st_addr      = cell_addr - ADDR_W'(1);
                        st_cell      = make_cell(CHAR_SPACE, cur_attr_reg);
                    end
                    else if (!is_newline)
                    begin
                        st_req.valid = 1'b1;
                    end
                end
                FUNC_CLEAR:
                begin
                    st_req.valid = 1'b1;
                    st_req.op    = OP_FILL;
                    st_cell      = make_cell(CHAR_SPACE, def_attr_reg);
                end
                FUNC_READ:
                begin
                    st_req.valid = rd_in_range;
                    st_req.op    = OP_READ;
                    st_addr      = ADDR_W'(idx_reg);
                end
                FUNC_SET_ATTR:
                begin
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == T_SCROLL)
        begin
            st_req.valid = 1'b1;
            st_req.op    = OP_SCROLL;
            st_cell      = make_cell(CHAR_SPACE, cur_attr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            func_reg         <= FUNC_PRINT;
            char_reg         <= '0;
            idx_reg          <= '0;
            attr_in_reg      <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
            cur_attr_reg     <= ATTR_AT_RESET;
            def_attr_reg     <= ATTR_AT_RESET;
            scrolled_reg     <= 1'b0;
            rd_hit_reg       <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            rsp_pos_reg      <= '0;
            rsp_char_reg     <= '0;
            rsp_attr_reg     <= '0;
            rsp_scrolled_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                def_attr_reg <= cfg_wr_data;
            end
            // T_DONE reloads the result register itself
            if (rsp_valid_reg && rsp.ready && state_reg != T_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                T_IDLE:
                begin
                    if (req.valid && !st_busy)
                    begin
                        func_reg     <= func_t'(req.func);
                        char_reg     <= req.char_code;
                        idx_reg      <= req.cell_index;
                        attr_in_reg  <= req.attribute_value;
                        scrolled_reg <= 1'b0;
                        rd_hit_reg   <= 1'b0;
                        state_reg    <= T_EXEC;
                    end
                end
                T_EXEC:
                begin
                    state_reg <= T_DONE;
                    unique case (func_reg)
                        FUNC_PRINT:
                        begin
                            if (is_backspace)
                            begin
                                if (col_reg != '0)
                                begin
                                    col_reg <= col_reg - 1'b1;
                                end
                            end
                            else if (is_newline || at_last_col)
                            begin
                                col_reg <= '0;
                                if (at_last_row)
                                begin
                                    // cursor stays on the last row
                                    state_reg <= T_SCROLL;
                                end
                                else
                                begin
                                    row_reg <= row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                col_reg <= col_reg + 1'b1;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            cur_attr_reg <= def_attr_reg;
                            col_reg      <= '0;
                            row_reg      <= '0;
                            state_reg    <= T_WAIT;
                        end
                        FUNC_READ:
                        begin
                            rd_hit_reg <= rd_in_range;
                        end
                        FUNC_SET_ATTR:
                        begin
                            cur_attr_reg <= attr_in_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                T_SCROLL:
                begin
                    scrolled_reg <= 1'b1;
                    state_reg    <= T_WAIT;
                end
                T_WAIT:
                begin
                    if (!st_busy)
                    begin
                        state_reg <= T_DONE;
                    end
                end
                T_DONE:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg    <= 1'b1;
                        rsp_pos_reg      <= 11'(cell_addr);
                        rsp_char_reg     <= rd_hit_reg ? st_rdata[7:0] : 8'h00;
                        rsp_attr_reg     <= rd_hit_reg ? st_rdata[15:8] : 8'h00;
                        rsp_scrolled_reg <= scrolled_reg;
                        state_reg        <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    tcw_store #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (st_req),
        .addr    (st_addr),
        .wr_cell (st_cell),
        .busy    (st_busy),
        .rdata   (st_rdata)
    );

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.cursor_position = rsp_pos_reg;
    assign rsp.read_char       = rsp_char_reg;
    assign rsp.read_attribute  = rsp_attr_reg;
    assign rsp.scrolled        = rsp_scrolled_reg;

endmodule

`default_nettype wire

// File: hdl/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [10:0] rsp_cursor_position,
    input logic        rsp_scrolled
);

    localparam int CELLS = COLUMNS * ROWS;

    `TCW_ASSERT_NEXT(a_rsp_held, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    // one request in flight: ready drops right after an accept
    `TCW_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)
    `TCW_ASSERT_SAME(a_pos_range, clk, rst_n, rsp_valid,
        (CELLS > 2048) || (32'(rsp_cursor_position) < 32'(CELLS)))
    // a scroll leaves the cursor on the bottom row
    `TCW_ASSERT_SAME(a_scroll_bottom, clk, rst_n, rsp_valid && rsp_scrolled,
        (CELLS > 2048) || (32'(rsp_cursor_position) >= 32'(COLUMNS * (ROWS - 1))))

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_cursor_position (rsp.cursor_position),
    .rsp_scrolled        (rsp.scrolled)
);

`default_nettype wire
